FILE: hdl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_AT(label, clk, rst_n, !(cond))

`endif

FILE: hdl/mat_pkg.sv
// Types, constants and codes of the minute alarm table.
`default_nettype none

package mat_pkg;

	// table geometry
	localparam int ENTRIES      = 16;
	localparam int MESSAGE_BITS = 16;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int KEY_W        = 20;

	// time constants
	localparam logic [10:0] MINUTES_PER_DAY  = 11'd1440;
	localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
	localparam logic [4:0]  MAX_HOUR         = 5'd23;
	localparam logic [5:0]  MAX_MINUTE       = 6'd59;

	// register reset values
	localparam logic [15:0] TICK_INTERVAL_RESET = 16'd1000;
	localparam logic [11:0] MIN_YEAR_RESET      = 12'd2024;

	// command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_ADD     = 3'd1;
	localparam logic [2:0] CMD_REMOVE  = 3'd2;
	localparam logic [2:0] CMD_CONSUME = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;

	// register indexes
	localparam logic CFG_TICK_INTERVAL = 1'b0;
	localparam logic CFG_MIN_YEAR      = 1'b1;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] now_ms;
		logic        time_valid;
		logic [11:0] year;
		logic [8:0]  day_of_year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic        daily;
		logic [15:0] message_in;
		logic [7:0]  entry_index;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] message_out;
		logic [4:0]  entry_hour;
		logic [5:0]  entry_minute;
		logic        entry_daily;
		logic [6:0]  alarm_count;
		logic        fire_pending;
	} result_t;

	typedef struct packed {
		logic [4:0]              hour;
		logic [5:0]              minute;
		logic                    repeats;
		logic [MESSAGE_BITS-1:0] message;
		logic [KEY_W-1:0]        fire_key;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic stamp;
		logic add_wr;
		logic consume;
		logic read_load;
		logic fire;
		logic step;
		logic shift_step;
		logic shift_end;
		logic set_ok;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] command;
		logic       empty;
		logic       pending;
		logic       early;
		logic       time_bad;
		logic       add_ok;
		logic       idx_ok;
		logic       match;
		logic       repeats;
		logic       last;
	} status_t;

endpackage

`default_nettype wire

FILE: hdl/mat_ctrl.sv
// Controller state machine of the minute alarm table.
`default_nettype none

module mat_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  mat_pkg::status_t  status,
	output mat_pkg::ctrl_t    ctrl,
	output logic              busy,
	output logic              done
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_RESP;
				case (status.command)
					mat_pkg::CMD_TICK: begin
						if (!status.empty && !status.pending && !status.early) begin
							ctrl.stamp = 1'b1;
							if (!status.time_bad) begin
								state_d = S_SCAN;
							end
						end
					end
					mat_pkg::CMD_ADD: begin
						if (status.add_ok) begin
							ctrl.add_wr = 1'b1;
							ctrl.set_ok = 1'b1;
						end
					end
					mat_pkg::CMD_REMOVE: begin
						if (status.idx_ok) begin
							ctrl.set_ok = 1'b1;
							state_d     = S_SHIFT;
						end
					end
					mat_pkg::CMD_CONSUME: begin
						if (status.pending) begin
							ctrl.consume = 1'b1;
						end
					end
					mat_pkg::CMD_READ: begin
						if (status.idx_ok) begin
							ctrl.read_load = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				// fire the first match, drop it if one-shot
				if (status.match) begin
					ctrl.fire   = 1'b1;
					ctrl.set_ok = 1'b1;
					state_d     = status.repeats ? S_RESP : S_SHIFT;
				end else if (status.last) begin
					state_d = S_RESP;
				end else begin
					ctrl.step = 1'b1;
				end
			end
			S_SHIFT: begin
				// close the gap one entry a cycle
				if (status.last) begin
					ctrl.shift_end = 1'b1;
					state_d        = S_RESP;
				end else begin
					ctrl.shift_step = 1'b1;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

FILE: hdl/mat_dpath.sv
// Datapath of the minute alarm table: entry table, counters and result.
`default_nettype none

module mat_dpath (
	input  wire               clk,
	input  wire               arst_n,
	input  mat_pkg::item_t    item,
	input  wire               cfg_we,
	input  wire               cfg_index,
	input  wire  [15:0]       cfg_data,
	input  mat_pkg::ctrl_t    ctrl,
	output mat_pkg::status_t  status,
	output mat_pkg::result_t  result
);

	localparam int IW = mat_pkg::IDX_W;
	localparam int CW = mat_pkg::CNT_W;
	localparam int KW = mat_pkg::KEY_W;
	localparam int MW = mat_pkg::MESSAGE_BITS;

	// configuration
	logic [15:0] interval_q;
	logic [11:0] min_year_q;

	// captured beat
	logic [2:0]  cmd_q;
	logic [31:0] now_q;
	logic        tvalid_q;
	logic [11:0] year_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic        daily_q;
	logic [15:0] msg_in_q;
	logic [7:0]  index_q;
	logic [KW-1:0] key_q;
	logic [IW-1:0] walk_q;

	// table and global state
	mat_pkg::entry_t tbl_q [mat_pkg::ENTRIES];
	logic [mat_pkg::ENTRIES-1:0] fired_q;
	logic [CW-1:0] total_q;
	logic          pending_q;
	logic [MW-1:0] pend_msg_q;
	logic [31:0]   last_tick_q;

	// result
	logic        res_ok_q;
	logic [15:0] res_msg_q;
	logic [4:0]  res_hour_q;
	logic [5:0]  res_minute_q;
	logic        res_daily_q;

	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   nxt_addr;
	mat_pkg::entry_t rd;
	mat_pkg::entry_t nxt;
	logic [IW-1:0]   wr_addr_add;
	logic [KW-1:0]   key_in;
	logic [31:0]     elapsed;

	assign rd_addr     = walk_q;
	assign nxt_addr    = IW'(walk_q + IW'(1));
	assign rd          = tbl_q[rd_addr];
	assign nxt         = tbl_q[nxt_addr];
	assign wr_addr_add = total_q[IW-1:0];
	assign key_in      = KW'(KW'(item.day_of_year) * KW'(mat_pkg::MINUTES_PER_DAY)
		+ KW'(item.hour) * KW'(mat_pkg::MINUTES_PER_HOUR) + KW'(item.minute));
	assign elapsed     = now_q - last_tick_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= mat_pkg::TICK_INTERVAL_RESET;
			min_year_q <= mat_pkg::MIN_YEAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mat_pkg::CFG_TICK_INTERVAL: interval_q <= cfg_data;
				mat_pkg::CFG_MIN_YEAR:      min_year_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// hold the accepted beat and advance the walk index
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q    <= item.command;
			now_q    <= item.now_ms;
			tvalid_q <= item.time_valid;
			year_q   <= item.year;
			hour_q   <= item.hour;
			minute_q <= item.minute;
			daily_q  <= item.daily;
			msg_in_q <= item.message_in;
			index_q  <= item.entry_index;
			key_q    <= key_in;
			walk_q   <= (item.command == mat_pkg::CMD_TICK) ? '0 : item.entry_index[IW-1:0];
		end else if (ctrl.step || ctrl.shift_step) begin
			walk_q <= IW'(walk_q + IW'(1));
		end
	end

	// update table payload
	always_ff @(posedge clk) begin
		if (ctrl.add_wr) begin
			tbl_q[wr_addr_add].hour     <= hour_q;
			tbl_q[wr_addr_add].minute   <= minute_q;
			tbl_q[wr_addr_add].repeats  <= daily_q;
			tbl_q[wr_addr_add].message  <= MW'(msg_in_q);
			tbl_q[wr_addr_add].fire_key <= '0;
		end else if (ctrl.fire) begin
			tbl_q[walk_q].fire_key <= key_q;
		end else if (ctrl.shift_step) begin
			tbl_q[walk_q] <= nxt;
		end
	end

	// update fired marks, count, pending message and last-tick time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q     <= '0;
			total_q     <= '0;
			pending_q   <= 1'b0;
			pend_msg_q  <= '0;
			last_tick_q <= '0;
		end else begin
			if (ctrl.add_wr) begin
				fired_q[wr_addr_add] <= 1'b0;
				total_q              <= CW'(total_q + CW'(1));
			end
			if (ctrl.fire) begin
				fired_q[walk_q] <= 1'b1;
				pending_q       <= 1'b1;
				pend_msg_q      <= rd.message;
			end
			if (ctrl.shift_step) begin
				fired_q[walk_q] <= fired_q[nxt_addr];
			end
			if (ctrl.shift_end) begin
				total_q <= CW'(total_q - CW'(1));
			end
			if (ctrl.consume) begin
				pending_q <= 1'b0;
			end
			if (ctrl.stamp) begin
				last_tick_q <= now_q;
			end
		end
	end

	// build result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ok_q     <= 1'b0;
			res_msg_q    <= '0;
			res_hour_q   <= '0;
			res_minute_q <= '0;
			res_daily_q  <= 1'b0;
		end else if (ctrl.capture) begin
			res_ok_q     <= 1'b0;
			res_msg_q    <= '0;
			res_hour_q   <= '0;
			res_minute_q <= '0;
			res_daily_q  <= 1'b0;
		end else begin
			if (ctrl.set_ok) begin
				res_ok_q <= 1'b1;
			end
			if (ctrl.consume) begin
				res_ok_q  <= 1'b1;
				res_msg_q <= 16'(pend_msg_q);
			end
			if (ctrl.read_load) begin
				res_ok_q     <= 1'b1;
				res_msg_q    <= 16'(rd.message);
				res_hour_q   <= rd.hour;
				res_minute_q <= rd.minute;
				res_daily_q  <= rd.repeats;
			end
		end
	end

	// status toward the controller
	always_comb begin
		status          = '0;
		status.command  = cmd_q;
		status.empty    = (total_q == '0);
		status.pending  = pending_q;
		status.early    = (elapsed < 32'(interval_q));
		status.time_bad = !tvalid_q || (year_q < min_year_q);
		status.add_ok   = (total_q < CW'(mat_pkg::ENTRIES))
			&& (hour_q <= mat_pkg::MAX_HOUR) && (minute_q <= mat_pkg::MAX_MINUTE);
		status.idx_ok   = (index_q < 8'(total_q));
		status.match    = (rd.hour == hour_q) && (rd.minute == minute_q)
			&& !(fired_q[rd_addr] && (rd.fire_key == key_q));
		status.repeats  = rd.repeats;
		status.last     = (CW'(CW'(walk_q) + CW'(1)) >= total_q);
	end

	// drive result beat
	always_comb begin
		result              = '0;
		result.ok           = res_ok_q;
		result.message_out  = res_msg_q;
		result.entry_hour   = res_hour_q;
		result.entry_minute = res_minute_q;
		result.entry_daily  = res_daily_q;
		result.alarm_count  = 7'(total_q);
		result.fire_pending = pending_q;
	end

endmodule

`default_nettype wire

FILE: hdl/minute_alarm_table.sv
// Top level of the minute alarm table: controller plus datapath.
//
// Channel   Signals                         Direction   Beat taken when
// command   start, busy, item               in          start && !busy
// result    done, result                    out         done (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_data     in          cfg_we
//
// For add, consume, read, rejected ticks and rejected removes the controller goes
// from the command beat through its decide state to the result strobe; busy is high
// throughout. A tick walks the table one entry a cycle (up to 16), and removing an
// entry, by command or after a one-shot alarm fires, shifts later entries down one
// a cycle. Busy stays high through walk and shift, and the next beat can be taken
// in the cycle after the result strobe.
// Reset clears count, pending flag, fired marks and last-tick time at once.
// The receiver takes each result beat as it comes.
`default_nettype none

module minute_alarm_table (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  mat_pkg::item_t    item,
	output logic              done,
	output mat_pkg::result_t  result,
	input  wire               cfg_we,
	input  wire               cfg_index,
	input  wire  [15:0]       cfg_data
);

	mat_pkg::ctrl_t   ctrl;
	mat_pkg::status_t status;

	mat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	mat_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: hdl/mat_checker.sv
// Port checker for the minute alarm table and its bind.
`default_nettype none
`include "assert_macros.svh"

module mat_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire              done,
	input mat_pkg::result_t result
);

	// an accepted command beat makes the block busy
	`ASSERT_AT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	// a result beat only comes while busy, and ends the command
	`ASSERT_AT(a_done_busy, clk, arst_n, done |-> busy)
	`ASSERT_AT(a_done_frees, clk, arst_n, done |=> (!busy && !done))
	// failed commands return no entry data
	`ASSERT_AT(a_fail_clean, clk, arst_n,
		(done && !result.ok) |-> (result.message_out == 16'd0 && result.entry_hour == 5'd0
		&& result.entry_minute == 6'd0 && !result.entry_daily))
	// the count never exceeds the table size
	`ASSERT_NEVER(a_count_range, clk, arst_n, result.alarm_count > 7'(mat_pkg::ENTRIES))

endmodule

bind minute_alarm_table mat_checker u_mat_checker (.*);

`default_nettype wire
